[rtl/hrp_pkg.sv]
// Shared types and constants for the HEX record parser.
// Depends on nothing; the design modules and the testbench import it.
package hrp_pkg;

  // Record start character
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Result codes
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_SUM_OK  = 3'd1,
    KIND_SUM_BAD = 3'd2,
    KIND_BAD_HEX = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  // One result transaction with its valid flag, parser to output stage
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic [7:0]  record_type;
  } result_t;

endpackage

[rtl/hrp_if.sv]
// Valid/ready channel interfaces for the HEX record parser.
// Character input channel and result output channel; no dependencies.
interface hrp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface hrp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_address;
  logic [7:0]  record_type;

  modport source (output valid, output kind, output data_byte, output byte_address,
                  output record_type, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_address,
                  input record_type, output ready);
endinterface

[rtl/hex_record_parser_checksum.sv]
// Top level of the Intel HEX record parser with checksum check.
// Depends on hrp_pkg, hrp_if, hrp_parser and hrp_out_stage.
//
// Usage:
//   char_i carries one ASCII character per transaction. result_o carries
//   at most one result per character: a data byte with its address and
//   record type, a checksum verdict, a bad hex digit or stream end.
//   Characters that complete nothing (colon, first digits of a field,
//   separator) give no result.
// Timing:
//   A character is taken into an input register, parsed by the parser and
//   its result lands in the result register, from which it is offered on
//   result_o. One character per cycle is sustained while result_o does
//   not stall; the parser updates its state for each character between
//   the input and result registers.
// Reset:
//   All parser state clears and the block waits for a colon; both
//   registers are emptied.
// Stall:
//   While a result waits on result_o the parser holds; at most one
//   character waits in the input register, and char_i.ready is low while
//   it is full and the parser holds.
module hex_record_parser_checksum (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrp_char_if.sink      char_i,
  hrp_result_if.source  result_o
);
  import hrp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       stage_ready;
  logic       fire;
  result_t    res;

  // Input register control
  assign fire         = in_valid_q && stage_ready;
  assign char_i.ready = !in_valid_q || fire;
  assign in_valid_d   = char_i.ready ? char_i.valid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
    end
  end

  hrp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .res_o  (res)
  );

  hrp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (stage_ready),
    .out_o   (result_o)
  );

endmodule

[rtl/hrp_parser.sv]
// Record parser: phase state machine, field assembly and checksum.
// Depends on hrp_pkg; result is combinational from state and character.
module hrp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  output hrp_pkg::result_t res_o
);
  import hrp_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_SEP  = 3'd6,
    PH_STOP = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  digit_cnt_q, digit_cnt_d;
  logic [15:0] field_q, field_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;

  logic        is_hex;
  logic [3:0]  nibble;
  logic [15:0] field_next;
  logic        field_done;
  logic [7:0]  idx_next;
  logic [7:0]  csum_total;

  // Hex digit decode
  always_comb begin
    is_hex = 1'b1;
    nibble = 4'd0;
    if (char_i inside {[8'h30:8'h39]}) begin
      nibble = 4'(char_i - 8'h30);
    end else if (char_i inside {[8'h61:8'h66]}) begin
      nibble = 4'(char_i - 8'h61 + 8'd10);
    end else if (char_i inside {[8'h41:8'h46]}) begin
      nibble = 4'(char_i - 8'h41 + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign field_next = {field_q[11:0], nibble};
  assign field_done = (phase_q == PH_ADDR) ? (digit_cnt_q == 2'd3) : (digit_cnt_q == 2'd1);
  assign idx_next   = idx_q + 8'd1;
  assign csum_total = sum_q + field_next[7:0];

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    field_d     = field_q;
    len_d       = len_q;
    addr_d      = addr_q;
    type_d      = type_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    res_o       = '{valid: 1'b0, kind: KIND_DATA, data_byte: 8'd0,
                    byte_address: 16'd0, record_type: 8'd0};

    if (fire_i) begin
      case (phase_q)
        PH_STOP: begin
        end
        PH_WAIT: begin
          if (char_i == COLON_CHAR) begin
            phase_d     = PH_LEN;
            digit_cnt_d = 2'd0;
            field_d     = 16'd0;
            sum_d       = 8'd0;
          end else begin
            phase_d    = PH_STOP;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_END;
          end
        end
        PH_SEP: begin
          phase_d = PH_WAIT;
        end
        default: begin
          if (!is_hex) begin
            phase_d     = PH_STOP;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BAD_HEX;
          end else if (!field_done) begin
            field_d     = field_next;
            digit_cnt_d = digit_cnt_q + 2'd1;
          end else begin
            field_d     = 16'd0;
            digit_cnt_d = 2'd0;
            case (phase_q)
              PH_LEN: begin
                len_d   = field_next[7:0];
                sum_d   = sum_q + field_next[7:0];
                phase_d = PH_ADDR;
              end
              PH_ADDR: begin
                addr_d  = field_next;
                sum_d   = sum_q + field_next[15:8] + field_next[7:0];
                phase_d = PH_TYPE;
              end
              PH_TYPE: begin
                type_d = field_next[7:0];
                sum_d  = sum_q + field_next[7:0];
                if (len_q == 8'd0) begin
                  // empty record marks end of stream
                  phase_d           = PH_STOP;
                  res_o.valid       = 1'b1;
                  res_o.kind        = KIND_END;
                  res_o.record_type = field_next[7:0];
                end else begin
                  idx_d   = 8'd0;
                  phase_d = PH_DATA;
                end
              end
              PH_DATA: begin
                sum_d              = sum_q + field_next[7:0];
                idx_d              = idx_next;
                res_o.valid        = 1'b1;
                res_o.kind         = KIND_DATA;
                res_o.data_byte    = field_next[7:0];
                res_o.byte_address = addr_q + {8'd0, idx_q};
                res_o.record_type  = type_q;
                if (idx_next == len_q) begin
                  phase_d = PH_CSUM;
                end
              end
              default: begin
                // checksum field
                res_o.valid       = 1'b1;
                res_o.record_type = type_q;
                if (csum_total == 8'd0) begin
                  phase_d    = PH_SEP;
                  res_o.kind = KIND_SUM_OK;
                end else begin
                  phase_d    = PH_STOP;
                  res_o.kind = KIND_SUM_BAD;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      digit_cnt_q <= 2'd0;
      field_q     <= 16'd0;
      len_q       <= 8'd0;
      addr_q      <= 16'd0;
      type_q      <= 8'd0;
      idx_q       <= 8'd0;
      sum_q       <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      field_q     <= field_d;
      len_q       <= len_d;
      addr_q      <= addr_d;
      type_q      <= type_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
    end
  end

  // Once stopped, the parser never leaves the stopped phase
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOP |=> phase_q == PH_STOP)
    else $error("parser left stopped phase");

  // Only the address field counts past two digits; a bad digit there freezes the count
  a_digit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_cnt_q[1] |-> (phase_q == PH_ADDR || phase_q == PH_STOP))
    else $error("digit count too large outside address field");

  // A result is only ever produced for a processed character
  a_res_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> fire_i && phase_q != PH_STOP && phase_q != PH_SEP)
    else $error("result without a processed character");

endmodule

[rtl/hrp_out_stage.sv]
// Result register between the parser and the output channel.
// Depends on hrp_pkg and hrp_result_if.
module hrp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hrp_pkg::result_t res_i,
  output logic             ready_o,
  hrp_result_if.source     out_o
);
  import hrp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // Room when empty or the held transaction leaves this cycle
  assign ready_o = !valid_q || out_o.ready;
  assign valid_d = res_i.valid ? 1'b1 : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded only when a new result arrives
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = data_q.kind;
  assign out_o.data_byte    = data_q.data_byte;
  assign out_o.byte_address = data_q.byte_address;
  assign out_o.record_type  = data_q.record_type;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> ready_o)
    else $error("result register overwritten while full");

  // Register only empties through a completed transaction
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(valid_q) |-> $past(out_o.ready))
    else $error("result dropped without transaction");

endmodule

[tb/hex_record_parser_checksum_tb.sv]
// Self-checking testbench for hex_record_parser_checksum: HEX text in, parsed results out.
// Depends on hrp_pkg, hrp_if and the block itself; needs no files at run time.
`timescale 1ns / 1ps

module hex_record_parser_checksum_tb;
  import hrp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    P_WAIT, P_LEN, P_ADDR, P_TYPE, P_DATA, P_CSUM, P_SEP, P_STOP
  } parse_phase_e;

  // Ways the stream is brought to its stop at the end of the run
  typedef enum int unsigned {
    END_NO_COLON, END_ZERO_LEN, END_BAD_DIGIT, END_BAD_SUM
  } stream_end_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic [7:0]  record_type;
  } parse_result_t;

  typedef struct {
    logic [7:0]    ch;
    bit            typed;
    parse_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hrp_char_if   char_bus ();
  hrp_result_if res_bus ();

  hex_record_parser_checksum u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .char_i   (char_bus),
    .result_o (res_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  parse_phase_e ph;
  logic [1:0]   nib_cnt;
  logic [15:0]  acc;
  logic [7:0]   rec_len;
  logic [15:0]  rec_addr;
  logic [7:0]   rec_type;
  logic [7:0]   byte_idx;
  logic [7:0]   sum;

  parse_result_t results_due[$];
  dir_row_t      dir_rows[$];
  logic [7:0]    rec_text[$];
  logic [7:0]    rec_sum;
  int unsigned   chars_sent = 0;
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  bit            calm;

  assign calm = (chars_sent >= 500) && (chars_sent < 700);

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] n);
    n = 4'd0;
    if (c >= "0" && c <= "9") begin
      n = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      n = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      n = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Next state and result for one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, output parse_result_t r);
    logic [3:0]  nib;
    logic [15:0] v;
    logic [7:0]  tot;
    int          need;
    r = '0;
    case (ph)
      P_STOP: return 1'b0;
      P_WAIT: begin
        if (c == COLON_CHAR) begin
          ph = P_LEN;
          nib_cnt = '0;
          acc = '0;
          sum = '0;
          return 1'b0;
        end
        ph = P_STOP;
        r.kind = KIND_END;
        return 1'b1;
      end
      P_SEP: begin
        ph = P_WAIT;
        return 1'b0;
      end
      default: ;
    endcase

    if (!hex_value(c, nib)) begin
      ph = P_STOP;
      r.kind = KIND_BAD_HEX;
      return 1'b1;
    end
    acc = {acc[11:0], nib};
    need = (ph == P_ADDR) ? 4 : 2;
    if (int'(nib_cnt) + 1 < need) begin
      nib_cnt = nib_cnt + 2'd1;
      return 1'b0;
    end
    nib_cnt = '0;
    v = acc;
    acc = '0;

    case (ph)
      P_LEN: begin
        rec_len = v[7:0];
        sum = sum + v[7:0];
        ph = P_ADDR;
        return 1'b0;
      end
      P_ADDR: begin
        rec_addr = v;
        sum = sum + v[15:8] + v[7:0];
        ph = P_TYPE;
        return 1'b0;
      end
      P_TYPE: begin
        rec_type = v[7:0];
        sum = sum + v[7:0];
        // zero-length record ends the stream right after its type
        if (rec_len == 8'd0) begin
          ph = P_STOP;
          r.kind = KIND_END;
          r.record_type = rec_type;
          return 1'b1;
        end
        byte_idx = '0;
        ph = P_DATA;
        return 1'b0;
      end
      P_DATA: begin
        r.kind = KIND_DATA;
        r.data_byte = v[7:0];
        r.byte_address = rec_addr + 16'(byte_idx);
        r.record_type = rec_type;
        sum = sum + v[7:0];
        byte_idx = byte_idx + 8'd1;
        if (byte_idx == rec_len) ph = P_CSUM;
        return 1'b1;
      end
      default: begin
        tot = sum + v[7:0];
        r.record_type = rec_type;
        if (tot == 8'd0) begin
          ph = P_SEP;
          r.kind = KIND_SUM_OK;
        end else begin
          ph = P_STOP;
          r.kind = KIND_SUM_BAD;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "a" : "A") + 8'(n - 4'd10);
  endfunction

  task automatic add_row(input logic [7:0] ch);
    dir_row_t row;
    row.ch = ch;
    row.typed = 1'b0;
    row.res = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_row_res(input logic [7:0] ch, input kind_e k, input logic [7:0] d,
                             input logic [15:0] a, input logic [7:0] t);
    dir_row_t row;
    row.ch = ch;
    row.typed = 1'b1;
    row.res = '{kind: k, data_byte: d, byte_address: a, record_type: t};
    dir_rows.push_back(row);
  endtask

  // Offer one character, wait for its transaction, then log what it should cause
  task automatic put_char(input logic [7:0] ch, input bit typed, input parse_result_t typed_res);
    parse_result_t r;
    bit            due;
    if (!calm && $urandom_range(99) < 7) begin
      repeat ($urandom_range(1, 2)) begin
        char_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= ch;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
    due = parse_char(ch, r);
    if (typed) results_due.push_back(typed_res);
    else if (due) results_due.push_back(r);
  endtask

  task automatic add_byte(input logic [7:0] b);
    rec_text.push_back(hex_char(b[7:4]));
    rec_text.push_back(hex_char(b[3:0]));
    rec_sum = rec_sum + b;
  endtask

  // Text of one record with its separator; skew of zero gives a good checksum
  task automatic make_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] typ, input logic [7:0] skew);
    logic [7:0] cs;
    rec_text.delete();
    rec_sum = '0;
    rec_text.push_back(COLON_CHAR);
    add_byte(len);
    add_byte(addr[15:8]);
    add_byte(addr[7:0]);
    add_byte(typ);
    for (int i = 0; i < int'(len); i++) add_byte(8'($urandom));
    cs = 8'd0 - rec_sum;
    cs = cs + skew;
    add_byte(cs);
    rec_text.push_back(8'($urandom));
  endtask

  task automatic make_random_record(input logic [7:0] skew);
    logic [7:0]  len;
    logic [15:0] addr;
    len = ($urandom_range(99) < 3) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(1, 16));
    addr = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(15)) : 16'($urandom);
    make_record(len, addr, 8'($urandom), skew);
  endtask

  task automatic send_text();
    foreach (rec_text[i]) put_char(rec_text[i], 1'b0, '0);
  endtask

  // Receiver: random stalls, one long hold-off, a calm stretch
  initial begin
    bit held = 1'b0;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && chars_sent >= 200) begin
        held = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_bus.ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected: kind %0d data %02h addr %04h type %02h",
                 $time, res_bus.kind, res_bus.data_byte, res_bus.byte_address,
                 res_bus.record_type);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (res_bus.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, res_bus.kind);
          errors++;
        end
        if (res_bus.data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %02h actual %02h", $time, want.data_byte,
                   res_bus.data_byte);
          errors++;
        end
        if (res_bus.byte_address !== want.byte_address) begin
          $display("%0t: byte_address expected %04h actual %04h", $time, want.byte_address,
                   res_bus.byte_address);
          errors++;
        end
        if (res_bus.record_type !== want.record_type) begin
          $display("%0t: record_type expected %02h actual %02h", $time, want.record_type,
                   res_bus.record_type);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hex_record_parser_checksum: mismatch");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    stream_end_e how;
    logic [7:0]  c;
    logic [3:0]  nib;
    int          pos;
    rst_n = 1'b0;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= 8'h00;
    ph = P_WAIT;
    nib_cnt = '0;
    acc = '0;
    rec_len = '0;
    rec_addr = '0;
    rec_type = '0;
    byte_idx = '0;
    sum = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two bytes at the top address, wrapping to zero, all-ones fields
    add_row(":");
    add_row("0");
    add_row("2");
    add_row("F");
    add_row("F");
    add_row("F");
    add_row("F");
    add_row("f");
    add_row("f");
    add_row("0");
    add_row_res("0", KIND_DATA, 8'h00, 16'hFFFF, 8'hFF);
    add_row("f");
    add_row_res("F", KIND_DATA, 8'hFF, 16'h0000, 8'hFF);
    add_row("0");
    add_row_res("2", KIND_SUM_OK, 8'h00, 16'h0000, 8'hFF);
    add_row(8'hFF);
    foreach (dir_rows[i]) put_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);

    // Random well-formed records
    while (chars_sent < RANDOM_CHARS) begin
      make_random_record(8'd0);
      send_text();
    end

    // One way to stop the stream, then noise that must be ignored
    how = stream_end_e'($urandom_range(3));
    case (how)
      END_NO_COLON: begin
        do c = 8'($urandom); while (c == COLON_CHAR);
        rec_text.delete();
        rec_text.push_back(c);
      end
      END_ZERO_LEN: make_record(8'd0, 16'($urandom), 8'($urandom), 8'd0);
      END_BAD_DIGIT: begin
        make_random_record(8'd0);
        pos = $urandom_range(1, rec_text.size() - 2);
        do c = 8'($urandom); while (hex_value(c, nib));
        rec_text[pos] = c;
      end
      default: make_random_record(8'($urandom_range(1, 255)));
    endcase
    repeat (16) rec_text.push_back(8'($urandom));
    send_text();
    char_bus.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("hex_record_parser_checksum: match");
    else $display("hex_record_parser_checksum: mismatch");
    $finish;
  end

endmodule
